### hw/rtl/crc_checked_frame_deframer_core_defines.svh
// Assertion macros used by the deframer parser.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Plain implication, checked on every rising clock edge outside reset.
`define CCFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CCFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ccfd_pkg.sv
// Package: types, constants and the CRC step shared by the deframer modules.
`default_nettype none
package ccfd_pkg;

   localparam int BUFFER_BYTES_DEF = 128;
   localparam int MAX_PAYLOAD_DEF  = 64;
   localparam int SYNC_LEN         = 8;
   localparam int HEAD_LEN         = 24;

   localparam logic [31:0] CRC_POLY = 32'hedb88320;
   localparam logic [31:0] CRC_ALL  = 32'hffffffff;

   // csr register indexes
   localparam logic REG_MAGIC   = 1'b0;
   localparam logic REG_VERSION = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SYNC,
      S_SYNC_RD,
      S_HDR,
      S_FLD,
      S_FLD_RD,
      S_EVAL,
      S_CRC,
      S_CRC_RD,
      S_CRC_CHK,
      S_EMIT_ISSUE,
      S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_VER,
      PH_LEN,
      PH_CRC,
      PH_ID,
      PH_TYPE
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        frame_valid;
      logic [15:0] msg_kind;
      logic [31:0] frame_tag;
      logic [6:0]  body_len;
      logic        last;
      logic        overflow_reset;
      logic        version_error;
      logic        length_error;
      logic        crc_error;
   } rsp_type;

   // one byte of the reflected CRC-32
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/ccfd_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module ccfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ccfd_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/ccfd_queue.sv
// Two-entry queue used on both sides of the frame parser.
`default_nettype none
module ccfd_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/ccfd_parser.sv
// Frame parser: circular frame store, sync search, header and CRC checks, result emission.
`default_nettype none
`include "crc_checked_frame_deframer_core_defines.svh"
module ccfd_parser #(
   parameter int BUFFER_BYTES = ccfd_pkg::BUFFER_BYTES_DEF,
   parameter int MAX_PAYLOAD  = ccfd_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [63:0]       magic_word,
   input  wire logic [15:0]       protocol_version,
   input  wire logic              in_empty,
   input  wire ccfd_pkg::req_type in_data,
   output logic                   in_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output ccfd_pkg::rsp_type      out_data
);

   localparam int PTR_W  = $clog2(BUFFER_BYTES);
   localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
   localparam logic [PTR_W:0]    BUF_P  = (PTR_W+1)'(BUFFER_BYTES);
   localparam logic [FILL_W-1:0] BUF_F  = FILL_W'(BUFFER_BYTES);
   localparam logic [FILL_W-1:0] SYNC_F = FILL_W'(ccfd_pkg::SYNC_LEN);
   localparam logic [FILL_W-1:0] HEAD_F = FILL_W'(ccfd_pkg::HEAD_LEN);
   localparam logic [PTR_W-1:0]  HEAD_P = PTR_W'(ccfd_pkg::HEAD_LEN);
   localparam logic [PTR_W-1:0]  SYNC_P = PTR_W'(ccfd_pkg::SYNC_LEN);
   localparam logic [31:0]       MAX_W  = 32'(MAX_PAYLOAD);

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= BUF_P) begin
         s = s - BUF_P;
      end
      return s[PTR_W-1:0];
   endfunction

   ccfd_pkg::state_type state_ff, state_in;
   ccfd_pkg::phase_type phase_ff, phase_in;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       newest_ff, newest_in;
   logic              seen_ff, seen_in;
   logic              skip_ff, skip_in;
   logic              chunk_last_ff, chunk_last_in;
   logic              ovf_ff, ovf_in;
   logic              verr_ff, verr_in;
   logic              lerr_ff, lerr_in;
   logic              cerr_ff, cerr_in;
   logic              got_ff, got_in;
   logic [15:0]       mtype_ff, mtype_in;
   logic [31:0]       rid_ff, rid_in;
   logic [6:0]        plen_ff, plen_in;
   logic [6:0]        len_ff, len_in;
   logic [PTR_W-1:0]  pay_start_ff, pay_start_in;
   logic [31:0]       crc_ff, crc_in;
   logic [31:0]       crcexp_ff, crcexp_in;
   logic [31:0]       acc_ff, acc_in;
   logic [6:0]        idx_ff, idx_in;

   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [PTR_W-1:0]  rd_addr;
   logic [7:0]        rd_data;

   logic [4:0]        fld_off;
   logic [1:0]        fld_last;
   logic [FILL_W-1:0] size_acc;
   logic [FILL_W-1:0] size_len;
   logic [6:0]        emit_n;
   logic              has_bytes;
   logic              magic_miss;
   logic              newer;
   logic              too_long;

   ccfd_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_data.data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (phase_ff)
         ccfd_pkg::PH_VER:  begin fld_off = 5'd8;  fld_last = 2'd1; end
         ccfd_pkg::PH_TYPE: begin fld_off = 5'd10; fld_last = 2'd1; end
         ccfd_pkg::PH_ID:   begin fld_off = 5'd12; fld_last = 2'd3; end
         ccfd_pkg::PH_LEN:  begin fld_off = 5'd16; fld_last = 2'd3; end
         ccfd_pkg::PH_CRC:  begin fld_off = 5'd20; fld_last = 2'd3; end
         default:           begin fld_off = 5'd8;  fld_last = 2'd1; end
      endcase
   end

   assign size_acc   = HEAD_F + FILL_W'(acc_ff[6:0]);
   assign size_len   = HEAD_F + FILL_W'(len_ff);
   assign has_bytes  = got_ff && (plen_ff != 7'd0);
   assign emit_n     = has_bytes ? plen_ff : 7'd1;
   assign magic_miss = (rd_data != magic_word[{idx_ff[2:0], 3'b000} +: 8]);
   assign newer      = !seen_ff || (acc_ff > newest_ff);
   assign too_long   = (acc_ff > MAX_W);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ccfd_pkg::S_IDLE: begin
            if (!in_empty) begin
               state_in = skip_ff ? ccfd_pkg::S_EMIT_ISSUE : ccfd_pkg::S_SYNC;
            end
         end
         ccfd_pkg::S_SYNC: begin
            state_in = (fill_ff < SYNC_F) ? ccfd_pkg::S_HDR : ccfd_pkg::S_SYNC_RD;
         end
         ccfd_pkg::S_SYNC_RD: begin
            if (magic_miss) begin
               state_in = ccfd_pkg::S_SYNC;
            end else if (idx_ff == 7'(ccfd_pkg::SYNC_LEN - 1)) begin
               state_in = ccfd_pkg::S_HDR;
            end
         end
         ccfd_pkg::S_HDR: begin
            state_in = (fill_ff < HEAD_F) ? ccfd_pkg::S_EMIT_ISSUE : ccfd_pkg::S_FLD;
         end
         ccfd_pkg::S_FLD: begin
            state_in = ccfd_pkg::S_FLD_RD;
         end
         ccfd_pkg::S_FLD_RD: begin
            if (idx_ff[1:0] == fld_last) begin
               state_in = ccfd_pkg::S_EVAL;
            end
         end
         ccfd_pkg::S_EVAL: begin
            case (phase_ff)
               ccfd_pkg::PH_VER: begin
                  state_in = (acc_ff[15:0] != protocol_version) ? ccfd_pkg::S_SYNC
                                                                : ccfd_pkg::S_FLD;
               end
               ccfd_pkg::PH_LEN: begin
                  if (too_long || (fill_ff < size_acc)) begin
                     state_in = ccfd_pkg::S_EMIT_ISSUE;
                  end else begin
                     state_in = ccfd_pkg::S_FLD;
                  end
               end
               ccfd_pkg::PH_CRC:  state_in = ccfd_pkg::S_CRC;
               ccfd_pkg::PH_ID:   state_in = newer ? ccfd_pkg::S_FLD : ccfd_pkg::S_SYNC;
               ccfd_pkg::PH_TYPE: state_in = ccfd_pkg::S_SYNC;
               default:           state_in = ccfd_pkg::S_IDLE;
            endcase
         end
         ccfd_pkg::S_CRC: begin
            state_in = (len_ff == 7'd0) ? ccfd_pkg::S_CRC_CHK : ccfd_pkg::S_CRC_RD;
         end
         ccfd_pkg::S_CRC_RD: begin
            if (idx_ff == len_ff - 7'd1) begin
               state_in = ccfd_pkg::S_CRC_CHK;
            end
         end
         ccfd_pkg::S_CRC_CHK: begin
            state_in = (crcexp_ff != ~crc_ff) ? ccfd_pkg::S_SYNC : ccfd_pkg::S_FLD;
         end
         ccfd_pkg::S_EMIT_ISSUE: begin
            state_in = ccfd_pkg::S_EMIT;
         end
         ccfd_pkg::S_EMIT: begin
            if (!out_full && (idx_ff == emit_n - 7'd1)) begin
               state_in = ccfd_pkg::S_IDLE;
            end
         end
         default: state_in = ccfd_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in      = phase_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      newest_in     = newest_ff;
      seen_in       = seen_ff;
      skip_in       = skip_ff;
      chunk_last_in = chunk_last_ff;
      ovf_in        = ovf_ff;
      verr_in       = verr_ff;
      lerr_in       = lerr_ff;
      cerr_in       = cerr_ff;
      got_in        = got_ff;
      mtype_in      = mtype_ff;
      rid_in        = rid_ff;
      plen_in       = plen_ff;
      len_in        = len_ff;
      pay_start_in  = pay_start_ff;
      crc_in        = crc_ff;
      crcexp_in     = crcexp_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = wrap_add(head_ff, fill_ff[PTR_W-1:0]);
      rd_addr       = head_ff;
      in_pop        = 1'b0;
      out_push      = 1'b0;

      out_data.payload_byte   = has_bytes ? rd_data : 8'd0;
      out_data.byte_valid     = has_bytes;
      out_data.frame_valid    = got_ff;
      out_data.msg_kind       = mtype_ff;
      out_data.frame_tag      = rid_ff;
      out_data.body_len       = plen_ff;
      out_data.last           = (idx_ff == emit_n - 7'd1);
      out_data.overflow_reset = ovf_ff;
      out_data.version_error  = verr_ff;
      out_data.length_error   = lerr_ff;
      out_data.crc_error      = cerr_ff;

      case (state_ff)
         ccfd_pkg::S_IDLE: begin
            if (!in_empty) begin
               in_pop        = 1'b1;
               chunk_last_in = in_data.chunk_last;
               ovf_in        = 1'b0;
               verr_in       = 1'b0;
               lerr_in       = 1'b0;
               cerr_in       = 1'b0;
               got_in        = 1'b0;
               mtype_in      = 16'd0;
               rid_in        = 32'd0;
               plen_in       = 7'd0;
               if (skip_ff) begin
                  if (in_data.chunk_last) begin
                     skip_in = 1'b0;
                  end
               end else begin
                  wr_en = 1'b1;
                  if (fill_ff == BUF_F) begin
                     // store full: parser cleared, byte lands at the head
                     wr_addr   = head_ff;
                     fill_in   = FILL_W'(1);
                     newest_in = 32'd0;
                     seen_in   = 1'b0;
                     ovf_in    = 1'b1;
                  end else begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
            end
         end
         ccfd_pkg::S_SYNC: begin
            idx_in  = 7'd0;
            rd_addr = head_ff;
         end
         ccfd_pkg::S_SYNC_RD: begin
            if (magic_miss) begin
               head_in = wrap_add(head_ff, PTR_W'(1));
               fill_in = fill_ff - FILL_W'(1);
            end else begin
               idx_in  = idx_ff + 7'd1;
               rd_addr = wrap_add(head_ff, PTR_W'(idx_ff) + PTR_W'(1));
            end
         end
         ccfd_pkg::S_HDR: begin
            phase_in = ccfd_pkg::PH_VER;
         end
         ccfd_pkg::S_FLD: begin
            idx_in  = 7'd0;
            acc_in  = 32'd0;
            rd_addr = wrap_add(head_ff, PTR_W'(fld_off));
         end
         ccfd_pkg::S_FLD_RD: begin
            acc_in[{idx_ff[1:0], 3'b000} +: 8] = rd_data;
            idx_in  = idx_ff + 7'd1;
            rd_addr = wrap_add(head_ff, PTR_W'(fld_off) + PTR_W'(idx_ff) + PTR_W'(1));
         end
         ccfd_pkg::S_EVAL: begin
            case (phase_ff)
               ccfd_pkg::PH_VER: begin
                  if (acc_ff[15:0] != protocol_version) begin
                     head_in = wrap_add(head_ff, SYNC_P);
                     fill_in = fill_ff - SYNC_F;
                     verr_in = 1'b1;
                  end else begin
                     phase_in = ccfd_pkg::PH_LEN;
                  end
               end
               ccfd_pkg::PH_LEN: begin
                  len_in = acc_ff[6:0];
                  if (too_long) begin
                     fill_in   = '0;
                     newest_in = 32'd0;
                     seen_in   = 1'b0;
                     lerr_in   = 1'b1;
                     skip_in   = !chunk_last_ff;
                  end else begin
                     phase_in = ccfd_pkg::PH_CRC;
                  end
               end
               ccfd_pkg::PH_CRC: begin
                  crcexp_in = acc_ff;
                  phase_in  = ccfd_pkg::PH_ID;
               end
               ccfd_pkg::PH_ID: begin
                  if (newer) begin
                     got_in       = 1'b1;
                     rid_in       = acc_ff;
                     plen_in      = len_ff;
                     pay_start_in = wrap_add(head_ff, HEAD_P);
                     newest_in    = acc_ff;
                     seen_in      = 1'b1;
                     phase_in     = ccfd_pkg::PH_TYPE;
                  end else begin
                     // stale id: frame dropped without a flag
                     head_in = wrap_add(head_ff, PTR_W'(size_len));
                     fill_in = fill_ff - size_len;
                  end
               end
               ccfd_pkg::PH_TYPE: begin
                  mtype_in = acc_ff[15:0];
                  head_in  = wrap_add(head_ff, PTR_W'(size_len));
                  fill_in  = fill_ff - size_len;
               end
               default: ;
            endcase
         end
         ccfd_pkg::S_CRC: begin
            crc_in  = ccfd_pkg::CRC_ALL;
            idx_in  = 7'd0;
            rd_addr = wrap_add(head_ff, HEAD_P);
         end
         ccfd_pkg::S_CRC_RD: begin
            crc_in  = ccfd_pkg::crc_byte(crc_ff, rd_data);
            idx_in  = idx_ff + 7'd1;
            rd_addr = wrap_add(head_ff, HEAD_P + PTR_W'(idx_ff) + PTR_W'(1));
         end
         ccfd_pkg::S_CRC_CHK: begin
            if (crcexp_ff != ~crc_ff) begin
               head_in = wrap_add(head_ff, PTR_W'(size_len));
               fill_in = fill_ff - size_len;
               cerr_in = 1'b1;
            end
         end
         ccfd_pkg::S_EMIT_ISSUE: begin
            idx_in  = 7'd0;
            rd_addr = pay_start_ff;
         end
         ccfd_pkg::S_EMIT: begin
            // hold the read address while the result queue is full
            rd_addr = wrap_add(pay_start_ff, PTR_W'(idx_ff));
            if (!out_full) begin
               out_push = 1'b1;
               idx_in   = idx_ff + 7'd1;
               rd_addr  = wrap_add(pay_start_ff, PTR_W'(idx_ff) + PTR_W'(1));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ccfd_pkg::S_IDLE;
         head_ff   <= '0;
         fill_ff   <= '0;
         newest_ff <= 32'd0;
         seen_ff   <= 1'b0;
         skip_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         newest_ff <= newest_in;
         seen_ff   <= seen_in;
         skip_ff   <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff      <= phase_in;
      chunk_last_ff <= chunk_last_in;
      ovf_ff        <= ovf_in;
      verr_ff       <= verr_in;
      lerr_ff       <= lerr_in;
      cerr_ff       <= cerr_in;
      got_ff        <= got_in;
      mtype_ff      <= mtype_in;
      rid_ff        <= rid_in;
      plen_ff       <= plen_in;
      len_ff        <= len_in;
      pay_start_ff  <= pay_start_in;
      crc_ff        <= crc_in;
      crcexp_ff     <= crcexp_in;
      acc_ff        <= acc_in;
      idx_ff        <= idx_in;
   end

   `CCFD_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= BUF_F, "fill beyond store")
   `CCFD_ASSERT_IMP(a_head_bound, clock, reset, 1'b1, {1'b0, head_ff} < BUF_P, "head out of range")
   `CCFD_ASSERT_IMP(a_skip_src, clock, reset, $rose(skip_ff), $past(state_ff == ccfd_pkg::S_EVAL), "skip set outside header check")
   `CCFD_ASSERT_NXT(a_last_idle, clock, reset, out_push && out_data.last, state_ff == ccfd_pkg::S_IDLE, "parser busy after final result")

endmodule
`default_nettype wire

### hw/rtl/crc_checked_frame_deframer_core.sv
// Top level: configuration registers, input queue, frame parser and result queue.
// Usage:
//  - req side is a queue: a byte with its chunk_last flag is transferred when push is high
//    and full is low. A two-entry queue sits in front of the parser.
//  - rsp side is a queue: while empty is low the oldest result is on the rsp_ ports and it
//    is transferred when pop is high. Every byte gives at least one result; a delivered
//    frame gives one result per payload byte, the last one flagged by rsp_last.
//  - csr_wr_en writes magic_word (index 0) or protocol_version (index 1); write only idle.
//  - The parser walks the store through its one read port. With fewer than 8 bytes held a
//    byte passes take, sync test, header test, issue and push; a magic scan reads each
//    candidate start byte by byte, so a byte behind a matched magic adds the scan, and
//    one waiting on its payload adds the version read and the length read as well.
//  - Completing a frame adds the CRC field read, the CRC walk over the payload bytes, the
//    request id read, the type read, a return to the sync test and one push per result.
//    A skipped byte passes take, issue and push.
//  - Reset clears the parser, the queues and the registers; no clearing pass is needed.
//  - When the receiver stalls the result queue fills, the parser waits on it, and full
//    rises once the input queue is taken up too. Nothing is lost.
`default_nettype none
module crc_checked_frame_deframer_core #(
   parameter int BUFFER_BYTES = ccfd_pkg::BUFFER_BYTES_DEF,
   parameter int MAX_PAYLOAD  = ccfd_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_chunk_last,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_frame_valid,
   output logic [15:0]      rsp_msg_kind,
   output logic [31:0]      rsp_frame_tag,
   output logic [6:0]       rsp_body_len,
   output logic             rsp_last,
   output logic             rsp_overflow_reset,
   output logic             rsp_version_error,
   output logic             rsp_length_error,
   output logic             rsp_crc_error,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int REQ_W = $bits(ccfd_pkg::req_type);
   localparam int RSP_W = $bits(ccfd_pkg::rsp_type);

   logic [63:0] magic_ff, magic_in;
   logic [15:0] version_ff, version_in;

   ccfd_pkg::req_type req_in;
   ccfd_pkg::req_type req_q;
   ccfd_pkg::rsp_type rsp_d;
   ccfd_pkg::rsp_type rsp_q;
   logic              in_empty;
   logic              in_pop;
   logic              out_full;
   logic              out_push;

   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ccfd_pkg::REG_MAGIC:   magic_in   = csr_wdata;
            ccfd_pkg::REG_VERSION: version_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= 64'd0;
         version_ff <= 16'd0;
      end else begin
         magic_ff   <= magic_in;
         version_ff <= version_in;
      end
   end

   assign req_in.data_byte  = req_data_byte;
   assign req_in.chunk_last = req_chunk_last;

   ccfd_queue #(
      .WIDTH (REQ_W)
   ) u_req_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (req_in),
      .full    (full),
      .pop     (in_pop),
      .empty   (in_empty),
      .rd_data (req_q)
   );

   ccfd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .magic_word       (magic_ff),
      .protocol_version (version_ff),
      .in_empty         (in_empty),
      .in_data          (req_q),
      .in_pop           (in_pop),
      .out_full         (out_full),
      .out_push         (out_push),
      .out_data         (rsp_d)
   );

   ccfd_queue #(
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (rsp_d),
      .full    (out_full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (rsp_q)
   );

   assign rsp_payload_byte   = rsp_q.payload_byte;
   assign rsp_byte_valid     = rsp_q.byte_valid;
   assign rsp_frame_valid    = rsp_q.frame_valid;
   assign rsp_msg_kind       = rsp_q.msg_kind;
   assign rsp_frame_tag      = rsp_q.frame_tag;
   assign rsp_body_len       = rsp_q.body_len;
   assign rsp_last           = rsp_q.last;
   assign rsp_overflow_reset = rsp_q.overflow_reset;
   assign rsp_version_error  = rsp_q.version_error;
   assign rsp_length_error   = rsp_q.length_error;
   assign rsp_crc_error      = rsp_q.crc_error;

endmodule
`default_nettype wire

### sim/crc_checked_frame_deframer_core_tb.sv
// Self-checking testbench for the magic-synchronised CRC-32 frame deframer.
`timescale 1ns / 100ps
`default_nettype none
module crc_checked_frame_deframer_core_tb;

   localparam int STORE_BYTES = 128;
   localparam int PAYLOAD_MAX = 64;
   localparam int CYCLE_LIMIT = 1000000;

   // kinds of generated traffic
   localparam int K_GOOD   = 0;
   localparam int K_STALE  = 1;
   localparam int K_BADCRC = 2;
   localparam int K_BADVER = 3;
   localparam int K_LONG   = 4;
   localparam int K_NOISE  = 5;

   typedef struct {
      logic [7:0] data;
      logic       chunk_end;
   } link_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = '0;
   logic        req_chunk_last = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_valid;
   logic [15:0] rsp_msg_kind;
   logic [31:0] rsp_frame_tag;
   logic [6:0]  rsp_body_len;
   logic        rsp_last;
   logic        rsp_overflow_reset;
   logic        rsp_version_error;
   logic        rsp_length_error;
   logic        rsp_crc_error;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [63:0] csr_wdata = '0;

   crc_checked_frame_deframer_core uut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_chunk_last(req_chunk_last),
      .empty(empty), .pop(pop),
      .rsp_payload_byte(rsp_payload_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_frame_valid(rsp_frame_valid), .rsp_msg_kind(rsp_msg_kind),
      .rsp_frame_tag(rsp_frame_tag), .rsp_body_len(rsp_body_len),
      .rsp_last(rsp_last), .rsp_overflow_reset(rsp_overflow_reset),
      .rsp_version_error(rsp_version_error), .rsp_length_error(rsp_length_error),
      .rsp_crc_error(rsp_crc_error),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // deframer shadow state
   logic [7:0]  fstore [STORE_BYTES];
   int          fill = 0;
   logic [31:0] newest_id = '0;
   bit          id_seen = 0;
   bit          skipping = 0;
   logic [63:0] cfg_magic = '0;
   logic [15:0] cfg_version = '0;

   ccfd_pkg::rsp_type expected_q [$];
   link_byte_type     pending_q [$];
   int          queued = 0;
   int          accepted = 0;
   int          errors = 0;
   int          results_seen = 0;
   int          frames_seen = 0;
   int          crc_drops = 0;
   int          ver_drops = 0;
   int          len_drops = 0;
   bit          calm = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          cycles = 0;
   link_byte_type next_item;

   // generator state
   logic [31:0] gen_id = 32'd1;

   function automatic logic [31:0] crc_of(input logic [7:0] q [$]);
      logic [31:0] c;
      c = ccfd_pkg::CRC_ALL;
      foreach (q[i]) begin
         c ^= {24'd0, q[i]};
         for (int b = 0; b < 8; b++) c = (c >> 1) ^ (c[0] ? ccfd_pkg::CRC_POLY : 32'd0);
      end
      return ~c;
   endfunction

   function automatic logic [31:0] rd32(input int at);
      return {fstore[at + 3], fstore[at + 2], fstore[at + 1], fstore[at]};
   endfunction

   function automatic void drop_bytes(input int n);
      if (n >= fill) begin
         fill = 0;
         return;
      end
      for (int i = 0; i < fill - n; i++) fstore[i] = fstore[i + n];
      fill -= n;
   endfunction

   function automatic void hunt_sync();
      bit ok;
      while (fill >= ccfd_pkg::SYNC_LEN) begin
         ok = 1;
         for (int i = 0; i < ccfd_pkg::SYNC_LEN; i++)
            if (fstore[i] != cfg_magic[8*i +: 8]) ok = 0;
         if (ok) break;
         drop_bytes(1);
      end
   endfunction

   function automatic void clear_parser();
      fill = 0;
      newest_id = '0;
      id_seen = 0;
   endfunction

   // works out the results of one accepted byte
   function automatic void deframe_byte(input logic [7:0] d, input logic cl);
      ccfd_pkg::rsp_type r;
      bit          ovf, verr, lerr, cerr, got;
      logic [15:0] mt;
      logic [31:0] rid, plen, ln, id;
      logic [7:0]  pay [PAYLOAD_MAX];
      logic [7:0]  body [$];
      int          n;
      r = '0;
      ovf = 0; verr = 0; lerr = 0; cerr = 0; got = 0;
      mt = '0; rid = '0; plen = '0;
      if (skipping) begin
         if (cl) skipping = 0;
         r.last = 1'b1;
         expected_q.push_back(r);
         return;
      end
      if (fill >= STORE_BYTES) begin
         clear_parser();
         ovf = 1;
      end
      fstore[fill] = d;
      fill++;
      hunt_sync();
      while (fill >= ccfd_pkg::HEAD_LEN) begin
         if (16'(rd32(8)) != cfg_version) begin
            drop_bytes(ccfd_pkg::SYNC_LEN);
            verr = 1;
            hunt_sync();
            continue;
         end
         ln = rd32(16);
         if (ln > PAYLOAD_MAX) begin
            clear_parser();
            lerr = 1;
            skipping = !cl;
            break;
         end
         if (fill < ccfd_pkg::HEAD_LEN + ln) break;
         body.delete();
         for (int i = 0; i < ln; i++) body.push_back(fstore[ccfd_pkg::HEAD_LEN + i]);
         if (rd32(20) != crc_of(body)) begin
            drop_bytes(ccfd_pkg::HEAD_LEN + ln);
            cerr = 1;
            hunt_sync();
            continue;
         end
         id = rd32(12);
         if (!id_seen || id > newest_id) begin
            got = 1;
            mt = 16'(rd32(10));
            rid = id;
            plen = ln;
            for (int i = 0; i < ln; i++) pay[i] = body[i];
            newest_id = id;
            id_seen = 1;
         end
         drop_bytes(ccfd_pkg::HEAD_LEN + ln);
         hunt_sync();
      end
      n = (got && plen > 0) ? int'(plen) : 1;
      for (int k = 0; k < n; k++) begin
         r = '0;
         r.payload_byte = (got && plen > 0) ? pay[k] : 8'd0;
         r.byte_valid = got && plen > 0;
         r.frame_valid = got;
         r.msg_kind = mt;
         r.frame_tag = rid;
         r.body_len = plen[6:0];
         r.last = (k == n - 1);
         r.overflow_reset = ovf;
         r.version_error = verr;
         r.length_error = lerr;
         r.crc_error = cerr;
         expected_q.push_back(r);
      end
   endfunction

   task automatic put_byte(input logic [7:0] d, input logic cl);
      link_byte_type it;
      it.data = d;
      it.chunk_end = cl;
      pending_q.push_back(it);
      queued++;
   endtask

   task automatic put_word(input logic [31:0] w, input int nbytes);
      for (int i = 0; i < nbytes; i++) put_byte(w[8*i +: 8], $urandom_range(0, 15) == 0);
   endtask

   task automatic add_frame(input int kind, input int len_pick);
      logic [7:0]  pl [$];
      logic [31:0] len, crc;
      logic [15:0] ver;
      if (kind == K_NOISE) begin
         repeat ($urandom_range(1, 6)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
         return;
      end
      if (kind == K_LONG)
         len = $urandom_range(0, 1) ? 32'd65 : ($urandom | 32'h80);
      else
         len = len_pick;
      if (kind != K_LONG)
         for (int i = 0; i < len; i++) pl.push_back(8'($urandom));
      crc = crc_of(pl);
      if (kind == K_BADCRC) crc ^= 32'd1 << $urandom_range(0, 31);
      ver = cfg_version;
      if (kind == K_BADVER) ver ^= 16'($urandom_range(1, 16'hffff));
      if (kind == K_GOOD) begin
         if ($urandom_range(0, 15) == 0) gen_id = $urandom;
         else gen_id += $urandom_range(1, 5000);
      end
      put_word(cfg_magic[31:0], 4);
      put_word(cfg_magic[63:32], 4);
      put_word({16'd0, ver}, 2);
      put_word($urandom, 2);
      put_word(gen_id, 4);
      put_word(len, 4);
      put_word(crc, 4);
      if (kind == K_LONG) begin
         // a later byte must close the chunk or everything after it is skipped
         repeat ($urandom_range(0, 5)) put_byte(8'($urandom), 1'b0);
         put_byte(8'($urandom), 1'b1);
         gen_id = $urandom_range(0, 255);
      end else begin
         foreach (pl[i]) put_byte(pl[i], (i == pl.size() - 1) && $urandom_range(0, 2) == 0);
      end
   endtask

   task automatic random_traffic(input int nbytes);
      int sel, target;
      target = queued + nbytes;
      while (queued < target) begin
         sel = $urandom_range(0, 19);
         add_frame(sel < 10 ? K_GOOD : sel < 12 ? K_STALE : sel < 14 ? K_BADCRC :
                   sel < 16 ? K_BADVER : sel < 17 ? K_LONG : K_NOISE,
                   $urandom_range(0, 11) == 0 ? PAYLOAD_MAX : $urandom_range(0, 12));
      end
   endtask

   task automatic csr_write(input logic idx, input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ccfd_pkg::REG_MAGIC) cfg_magic = value;
      else cfg_version = value[15:0];
   endtask

   task automatic wait_drained();
      while (accepted != queued || expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // input side
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            deframe_byte(req_data_byte, req_chunk_last);
            accepted++;
         end
         if (push && full) begin
            // hold the byte until it is taken
         end else if (req_gap > 0) begin
            req_gap--;
            push <= 1'b0;
         end else if (pending_q.size() > 0) begin
            next_item = pending_q.pop_front();
            req_data_byte <= next_item.data;
            req_chunk_last <= next_item.chunk_end;
            push <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 7);
         end else begin
            push <= 1'b0;
         end
      end
   end

   task automatic field_check(input string name, input logic [63:0] want, input logic [63:0] seen);
      if (want !== seen) begin
         errors++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
      end
   endtask

   // result side
   always @(posedge clock) begin
      ccfd_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected, byte %0h", $time,
                        rsp_payload_byte);
            end else begin
               want = expected_q.pop_front();
               field_check("payload_byte", want.payload_byte, rsp_payload_byte);
               field_check("byte_valid", want.byte_valid, rsp_byte_valid);
               field_check("frame_valid", want.frame_valid, rsp_frame_valid);
               field_check("msg_kind", want.msg_kind, rsp_msg_kind);
               field_check("frame_tag", want.frame_tag, rsp_frame_tag);
               field_check("body_len", want.body_len, rsp_body_len);
               field_check("last", want.last, rsp_last);
               field_check("overflow_reset", want.overflow_reset, rsp_overflow_reset);
               field_check("version_error", want.version_error, rsp_version_error);
               field_check("length_error", want.length_error, rsp_length_error);
               field_check("crc_error", want.crc_error, rsp_crc_error);
               if (want.last) begin
                  frames_seen += want.frame_valid;
                  crc_drops += want.crc_error;
                  ver_drops += want.version_error;
                  len_drops += want.length_error;
               end
            end
         end
         if (!calm && rsp_gap == 0 && $urandom_range(0, 9) == 0) rsp_gap = $urandom_range(1, 7);
         if (rsp_gap > 0) begin
            rsp_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("crc_checked_frame_deframer_core: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all-zero magic and version, edge bytes and an empty frame
      put_byte(8'h00, 1'b0);
      put_byte(8'hff, 1'b1);
      put_byte(8'h55, 1'b0);
      put_byte(8'haa, 1'b1);
      put_byte(8'hff, 1'b0);
      add_frame(K_GOOD, 0);
      random_traffic(40);
      wait_drained();

      csr_write(ccfd_pkg::REG_MAGIC, {$urandom, $urandom});
      csr_write(ccfd_pkg::REG_VERSION, $urandom);
      random_traffic(80);
      wait_drained();

      csr_write(ccfd_pkg::REG_MAGIC, 64'hffff_ffff_ffff_ffff);
      csr_write(ccfd_pkg::REG_VERSION, 64'hffff);
      add_frame(K_GOOD, PAYLOAD_MAX);
      random_traffic(60);
      wait_drained();

      calm = 1;
      csr_write(ccfd_pkg::REG_MAGIC, {$urandom, $urandom});
      csr_write(ccfd_pkg::REG_VERSION, 64'h0);
      random_traffic(50);
      wait_drained();

      $display("%0d bytes in, %0d results checked under four magic/version settings",
               accepted, results_seen);
      $display("%0d frames delivered, drops: %0d crc, %0d version, %0d length",
               frames_seen, crc_drops, ver_drops, len_drops);
      if (errors == 0)
         $display("crc_checked_frame_deframer_core: match");
      else
         $display("crc_checked_frame_deframer_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/ccfd_pkg.sv
hw/rtl/ccfd_ram.sv
hw/rtl/ccfd_queue.sv
hw/rtl/ccfd_parser.sv
hw/rtl/crc_checked_frame_deframer_core.sv
sim/crc_checked_frame_deframer_core_tb.sv
